### src/pam_kmer_window_scanner_core_defines.svh
// Assertion macros shared by the PAM k-mer window scanner sources.
`ifndef PAM_KMER_WINDOW_SCANNER_CORE_DEFINES_SVH
`define PAM_KMER_WINDOW_SCANNER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PKWS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkws same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PKWS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkws next-cycle check failed");

`endif

### src/pkws_pkg.sv
// Package with constants, types and helper functions of the PAM k-mer window scanner.
`timescale 1ns / 1ps

package pkws_pkg;

    localparam int GUIDE_LEN  = 20;
    localparam int PAM_MAX    = 8;
    localparam int WIN_DEPTH  = GUIDE_LEN + PAM_MAX;
    localparam int BASE_W     = 3;
    localparam int GUIDE_W    = 60;
    localparam int POS_W      = 32;
    localparam int PLEN_W     = 4;
    localparam int PAM_W      = 24;
    localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
    localparam int PSEL_W     = (PAM_MAX > 1) ? $clog2(PAM_MAX) : 1;
    localparam int GUIDE_KEEP = (GUIDE_LEN * BASE_W > GUIDE_W) ? (GUIDE_W / BASE_W) : GUIDE_LEN;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PAM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PAM_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAM_CODES  = 2'd1;

    localparam logic [BASE_W-1:0] BASE_T     = 3'd3;
    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

    localparam logic [PLEN_W-1:0] PAM_LENGTH_RESET = 4'd3;
    localparam logic [PAM_W-1:0]  PAM_CODES_RESET  = 24'd148;

    typedef logic [BASE_W-1:0] base_t;

    typedef struct packed {
        logic [GUIDE_W-1:0] guide;
        logic [POS_W-1:0]   position;
        logic               strand;
        logic               last;
    } result_t;

    function automatic base_t comp_base(input base_t b);
        base_t r;
        if (b < BASE_OTHER)
        begin
            r = BASE_T - b;
        end
        else
        begin
            r = BASE_OTHER;
        end
        return r;
    endfunction

    function automatic logic pam_ok(input base_t p, input base_t b);
        return (p >= BASE_OTHER) || (p == b);
    endfunction

endpackage

### src/pam_kmer_window_scanner_core.sv
// Top level of the PAM k-mer window scanner: base window, PAM compare and result queue.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid / in_stall    | base
//  out     | output    | out_valid / out_stall  | guide, position, strand, last
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One base is taken per cycle unless in_stall is high. The output port delivers one
// result per cycle unless out_stall is high, so a base matching on both strands
// yields two results; the eight-entry result queue absorbs this and raises in_stall
// only when it could not hold the results of the bases in flight. Reset clears the
// window, fill count, position counter and queue and presets the registers at once.
`timescale 1ns / 1ps
`include "pam_kmer_window_scanner_core_defines.svh"

module pam_kmer_window_scanner_core
    import pkws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BASE_W-1:0]     base,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [GUIDE_W-1:0]    guide,
    output logic [POS_W-1:0]      position,
    output logic                  strand,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PLEN_W-1:0]  pam_length_reg;
    logic [PAM_W-1:0]   pam_codes_reg;
    base_t              window_reg [WIN_DEPTH];
    logic [FILL_W-1:0]  fill_count_reg;
    logic [POS_W-1:0]   window_start_reg;
    logic               s1_valid_reg;

    result_t            queue_reg [FIFO_DEPTH];
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic [FIFO_AW:0]   wr_base;

    logic               in_accept;
    logic               out_accept;
    base_t              base_clamped;
    logic [PLEN_W-1:0]  plen;
    logic [PSEL_W-1:0]  plen_sel;
    logic [FILL_W:0]    win_len;
    logic               s1_check;
    logic [PAM_MAX-1:0] fwd_l;
    logic [PAM_MAX-1:0] rev_l;
    logic [GUIDE_W-1:0] gf_l [PAM_MAX];
    logic [GUIDE_W-1:0] guide_rev;
    logic               fwd_hit;
    logic               rev_hit;
    result_t            res_fwd;
    result_t            res_rev;
    logic [1:0]         n_push;

    assign cfg_ready  = 1'b1;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;

    assign in_stall = s1_valid_reg ? (count_reg > (FIFO_AW+1)'(FIFO_DEPTH - 4))
                                   : (count_reg > (FIFO_AW+1)'(FIFO_DEPTH - 2));

    assign base_clamped = (base > BASE_OTHER) ? BASE_OTHER : base;

    always_comb
    begin
        if (pam_length_reg == '0)
        begin
            plen = PLEN_W'(1);
        end
        else if (pam_length_reg > PLEN_W'(PAM_MAX))
        begin
            plen = PLEN_W'(PAM_MAX);
        end
        else
        begin
            plen = pam_length_reg;
        end
    end

    assign plen_sel = PSEL_W'(plen - PLEN_W'(1));
    assign win_len  = (FILL_W+1)'(GUIDE_LEN) + (FILL_W+1)'(plen);
    assign s1_check = s1_valid_reg && ({1'b0, fill_count_reg} >= win_len);

    // Each candidate PAM length gets its own compare with fixed window taps.
    always_comb
    begin
        for (int l = 1; l <= PAM_MAX; l++)
        begin
            fwd_l[l-1] = 1'b1;
            rev_l[l-1] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (!pam_ok(pam_codes_reg[BASE_W*i +: BASE_W], window_reg[WIN_DEPTH - l + i]))
                begin
                    fwd_l[l-1] = 1'b0;
                end
                if (!pam_ok(pam_codes_reg[BASE_W*i +: BASE_W],
                            comp_base(window_reg[PAM_MAX - 1 - i])))
                begin
                    rev_l[l-1] = 1'b0;
                end
            end
            gf_l[l-1] = '0;
            for (int j = 0; j < GUIDE_KEEP; j++)
            begin
                gf_l[l-1][BASE_W*j +: BASE_W] = window_reg[PAM_MAX - l + j];
            end
        end
        guide_rev = '0;
        for (int j = 0; j < GUIDE_KEEP; j++)
        begin
            guide_rev[BASE_W*j +: BASE_W] = comp_base(window_reg[WIN_DEPTH - 1 - j]);
        end
    end

    assign fwd_hit = s1_check && fwd_l[plen_sel];
    assign rev_hit = s1_check && rev_l[plen_sel];

    always_comb
    begin
        res_fwd.guide    = gf_l[plen_sel];
        res_fwd.position = window_start_reg;
        res_fwd.strand   = 1'b0;
        res_fwd.last     = !rev_hit;
        res_rev.guide    = guide_rev;
        res_rev.position = window_start_reg;
        res_rev.strand   = 1'b1;
        res_rev.last     = 1'b1;
    end

    assign n_push     = {1'b0, fwd_hit} + {1'b0, rev_hit};
    assign count_next = count_reg + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(out_accept);
    assign wr_base    = count_reg - (FIFO_AW+1)'(out_accept);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pam_length_reg <= PAM_LENGTH_RESET;
            pam_codes_reg  <= PAM_CODES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PAM_LENGTH)
            begin
                pam_length_reg <= cfg_data[PLEN_W-1:0];
            end
            else if (cfg_index == CFG_PAM_CODES)
            begin
                pam_codes_reg <= cfg_data[PAM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_DEPTH; k++)
            begin
                window_reg[k] <= '0;
            end
            fill_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                for (int k = 0; k < WIN_DEPTH - 1; k++)
                begin
                    window_reg[k] <= window_reg[k+1];
                end
                window_reg[WIN_DEPTH-1] <= base_clamped;
                if (fill_count_reg < FILL_W'(WIN_DEPTH))
                begin
                    fill_count_reg <= fill_count_reg + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
        end
        else if (s1_check)
        begin
            window_start_reg <= window_start_reg + POS_W'(1);
        end
    end

    // The queue shifts toward entry 0 on each output transaction; new results land
    // just above the entries that remain.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FIFO_DEPTH; k++)
        begin
            if ((fwd_hit || rev_hit) && (wr_base == (FIFO_AW+1)'(k)))
            begin
                queue_reg[k] <= fwd_hit ? res_fwd : res_rev;
            end
            else if (fwd_hit && rev_hit && ((wr_base + (FIFO_AW+1)'(1)) == (FIFO_AW+1)'(k)))
            begin
                queue_reg[k] <= res_rev;
            end
            else if (out_accept)
            begin
                queue_reg[k] <= queue_reg[(k < FIFO_DEPTH - 1) ? k + 1 : k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign guide    = queue_reg[0].guide;
    assign position = queue_reg[0].position;
    assign strand   = queue_reg[0].strand;
    assign last     = queue_reg[0].last;

    `PKWS_ASSERT_IMP(a_room_for_eval, s1_valid_reg, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
    `PKWS_ASSERT_IMP(a_rev_is_last, out_valid && strand, last)
    `PKWS_ASSERT_NXT(a_pos_hold, !s1_check, $stable(window_start_reg))

endmodule
